// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds at every clock edge
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that an expression is never true
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and arctangent table of the CORDIC converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int IN_W    = 16;
  localparam int FRAC_W  = 16;
  localparam int STAGES  = 16;
  localparam int XY_W    = IN_W + FRAC_W + 4;
  localparam int Z_W     = 34;
  localparam int GAIN_W  = 32;
  localparam int PROD_W  = IN_W + GAIN_W;
  localparam int RND_W   = XY_W - FRAC_W;
  localparam int H_W     = XY_W - 1 - GAIN_W;
  localparam int MAG_W   = GAIN_W + H_W + 1;

  localparam logic [GAIN_W-1:0] GAIN      = 32'h9B74EDA8;
  localparam logic [Z_W-1:0]    Z_HALF    = Z_W'(64'h8000_0000);
  localparam logic [31:0]       ANG_ROUND = 32'h0000_8000;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_RECT  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic signed [15:0]  x_in;
    logic signed [15:0]  y_in;
    logic [15:0]         radius_in;
    logic [15:0]         angle_in;
  } request_t;

  typedef struct packed {
    logic                   valid;
    opcode_t                opcode;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic [15:0]        radius_out;
    logic [15:0]        angle_out;
    logic               saturated;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpc_prep.sv =====
// ----------------------------------------------------------------------------
// rpc_prep
// Two input stages: fold the left half plane or back half turn, scale the
// radius by the inverse CORDIC gain and seed the x, y and angle registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_prep import rpc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     req_valid,
  input  wire request_t req,
  output cordic_t       seed
);

  logic                   a_valid;
  opcode_t                a_op;
  logic                   a_zero;
  logic                   a_flip;
  logic signed [XY_W-1:0] a_x;
  logic signed [XY_W-1:0] a_y;
  logic signed [Z_W-1:0]  a_z;
  logic [PROD_W-1:0]      a_prod;

  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;
  logic                   left;
  logic                   flip;
  logic [31:0]            zr;
  logic signed [Z_W-1:0]  z_seed;
  logic signed [XY_W-1:0] gx;

  always_comb begin
    xe   = XY_W'(req.x_in) <<< FRAC_W;
    ye   = XY_W'(req.y_in) <<< FRAC_W;
    left = req.x_in[15];
    flip = req.angle_in[15] ^ req.angle_in[14];
    zr   = {req.angle_in ^ {flip, 15'd0}, 16'd0};
    if (req.opcode == OP_TO_RECT) begin
      z_seed = Z_W'($signed(zr));
    end else begin
      z_seed = left ? Z_HALF : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= req.opcode;
      a_zero <= (req.x_in == 16'sd0) && (req.y_in == 16'sd0);
      a_flip <= flip;
      a_x    <= left ? -xe : xe;
      a_y    <= left ? -ye : ye;
      a_z    <= z_seed;
      a_prod <= PROD_W'(req.radius_in) * PROD_W'(GAIN);
    end
  end

  assign gx = XY_W'(a_prod[PROD_W-1:GAIN_W-FRAC_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed.valid <= 1'b0;
    end else if (en) begin
      seed.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seed.opcode <= a_op;
      seed.zero   <= a_zero;
      seed.z      <= a_z;
      if (a_op == OP_TO_RECT) begin
        seed.x <= a_flip ? -gx : gx;
        seed.y <= '0;
      end else begin
        seed.x <= a_x;
        seed.y <= a_y;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpc_cordic.sv =====
// ----------------------------------------------------------------------------
// rpc_cordic
// Unrolled CORDIC core, one micro-rotation per register stage; the sign of
// y steers vectoring and the sign of the residual angle steers rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cordic import rpc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire cordic_t seed,
  output cordic_t      done
);

  cordic_t pipe [0:STAGES];

  assign pipe[0] = seed;
  assign done    = pipe[STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] cx;
    logic signed [XY_W-1:0] cy;
    logic signed [Z_W-1:0]  cz;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    logic                   pos;

    always_comb begin
      cx  = pipe[i].x;
      cy  = pipe[i].y;
      cz  = pipe[i].z;
      xs  = cx >>> i;
      ys  = cy >>> i;
      at  = Z_W'(ATAN_TAB[i]);
      pos = (pipe[i].opcode == OP_TO_RECT) ? !cz[Z_W-1] : cy[XY_W-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1].valid <= 1'b0;
      end else if (en) begin
        pipe[i+1].valid <= pipe[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[i+1].opcode <= pipe[i].opcode;
        pipe[i+1].zero   <= pipe[i].zero;
        if (pos) begin
          pipe[i+1].x <= cx - ys;
          pipe[i+1].y <= cy + xs;
          pipe[i+1].z <= cz - at;
        end else begin
          pipe[i+1].x <= cx + ys;
          pipe[i+1].y <= cy - xs;
          pipe[i+1].z <= cz + at;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpc_post.sv =====
// ----------------------------------------------------------------------------
// rpc_post
// Two output stages: remove the gain from the magnitude, round the angle
// and the coordinates, then clip and blank the fields an opcode leaves unused.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_post import rpc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire cordic_t done,
  output result_t      res
);

  logic                    p_valid;
  opcode_t                 p_op;
  logic                    p_zero;
  logic [2*GAIN_W-1:0]     p_prod;
  logic [H_W-1:0]          p_h;
  logic [15:0]             p_angle;
  logic signed [RND_W-1:0] p_rx;
  logic signed [RND_W-1:0] p_ry;

  logic [XY_W-1:0]         xc;
  logic [31:0]             zsum;
  logic signed [XY_W-1:0]  xr;
  logic signed [XY_W-1:0]  yr;

  localparam logic signed [XY_W-1:0]  XY_HALF = XY_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [RND_W-1:0] SAT_HI  = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_LO  = -RND_W'(32767);
  localparam logic [MAG_W-1:0]        MAG_HALF = MAG_W'(1) << (FRAC_W - 1);
  localparam logic [MAG_W-FRAC_W-1:0] MAG_MAX  = (MAG_W-FRAC_W)'(16'hFFFF);

  always_comb begin
    xc   = done.x[XY_W-1] ? '0 : done.x;
    zsum = done.z[31:0] + ANG_ROUND;
    xr   = done.x + XY_HALF;
    yr   = done.y + XY_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= done.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_op    <= done.opcode;
      p_zero  <= done.zero;
      p_prod  <= (2*GAIN_W)'(xc[GAIN_W-1:0]) * (2*GAIN_W)'(GAIN);
      p_h     <= xc[XY_W-2:GAIN_W];
      p_angle <= zsum[31:16];
      p_rx    <= xr[XY_W-1:FRAC_W];
      p_ry    <= yr[XY_W-1:FRAC_W];
    end
  end

  logic [MAG_W-1:0]        mag;
  logic [MAG_W-FRAC_W-1:0] magi;
  logic                    clip_x;
  logic                    clip_y;
  logic signed [15:0]      sx;
  logic signed [15:0]      sy;

  always_comb begin
    mag    = MAG_W'(p_h) * MAG_W'(GAIN) + MAG_W'(p_prod[2*GAIN_W-1:GAIN_W]) + MAG_HALF;
    magi   = mag[MAG_W-1:FRAC_W];
    clip_x = (p_rx > SAT_HI) || (p_rx < SAT_LO);
    clip_y = (p_ry > SAT_HI) || (p_ry < SAT_LO);
    sx     = (p_rx > SAT_HI) ? 16'sd32767 : (p_rx < SAT_LO) ? -16'sd32767 : p_rx[15:0];
    sy     = (p_ry > SAT_HI) ? 16'sd32767 : (p_ry < SAT_LO) ? -16'sd32767 : p_ry[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p_op == OP_TO_RECT) begin
        res.x_out      <= sx;
        res.y_out      <= sy;
        res.saturated  <= clip_x || clip_y;
        res.radius_out <= '0;
        res.angle_out  <= '0;
      end else begin
        res.x_out      <= '0;
        res.y_out      <= '0;
        res.saturated  <= 1'b0;
        if (p_zero) begin
          res.radius_out <= '0;
          res.angle_out  <= '0;
        end else begin
          res.radius_out <= (magi > MAG_MAX) ? 16'hFFFF : magi[15:0];
          res.angle_out  <= p_angle;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rect_polar_converter.sv =====
// ----------------------------------------------------------------------------
// rect_polar_converter
// Pipelined CORDIC converter between rectangular and polar coordinates.
//
// channel  dir  tdata (low bit up)                       tuser
// s_*      in   x_in, y_in, radius_in, angle_in (64)     opcode
// m_*      out  x_out, y_out, radius_out, angle_out (64) saturated
//
// One transaction per cycle in and out when neither side stalls.
// Pipeline: 2 setup stages, 16 CORDIC stages, 2 finishing stages and
// the output register.
// Reset clears only the valid bits; no clearing pass.
// A skid register behind the output keeps s_tready a flop: it drops in the
// cycle after a stalled output meets a second finished result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rect_polar_converter import rpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // x_in, y_in, radius_in, angle_in
  input  wire logic        s_tuser,   // opcode
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // x_out, y_out, radius_out, angle_out
  output      logic        m_tuser    // saturated
);

  logic     en;
  logic     xfer;
  request_t req;
  cordic_t  seed;
  cordic_t  done;
  result_t  res;
  result_t  out_q;
  result_t  skid_q;
  logic     out_valid;
  logic     skid_valid;

  assign en       = !skid_valid;
  assign s_tready = !skid_valid;
  assign xfer     = en && res.valid;

  always_comb begin
    req.opcode    = opcode_t'(s_tuser);
    req.x_in      = s_tdata[15:0];
    req.y_in      = s_tdata[31:16];
    req.radius_in = s_tdata[47:32];
    req.angle_in  = s_tdata[63:48];
  end

  rpc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (s_tvalid),
    .req       (req),
    .seed      (seed)
  );

  rpc_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .seed (seed),
    .done (done)
  );

  rpc_post u_post (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .done (done),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= xfer;
      end
    end else if (xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (xfer) begin
        out_q <= res;
      end
    end else if (xfer) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_q.angle_out, out_q.radius_out, out_q.y_out, out_q.x_out};
  assign m_tuser  = out_q.saturated;

  `ASSERT_HOLDS(a_skid_needs_out, skid_valid |-> m_tvalid, "skid full with empty output")
  `ASSERT_HOLDS(a_ready_drop, $fell(s_tready) |-> $past(m_tvalid && !m_tready),
                "input stalled without output backpressure")
  `ASSERT_HOLDS(a_rect_no_polar, (m_tvalid && m_tuser) |-> (m_tdata[63:32] == 32'd0),
                "clipped result carries polar fields")
  `ASSERT_NEVER(a_no_min_x, m_tvalid && (m_tdata[15:0] == 16'h8000), "x_out beyond clip range")

endmodule

`default_nettype wire

// ===== tb/sv/rect_polar_converter_tb.sv =====
// ----------------------------------------------------------------------------
// rect_polar_converter_tb
// Streams conversion requests through the CORDIC converter in both
// directions and checks every result field by field against a bit-exact
// fixed-point CORDIC predictor kept in the bench. Directed corners come
// first, then random requests with random stalls on both sides, then a
// long back-to-back stretch with no stalls at all.
// ----------------------------------------------------------------------------
module rect_polar_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpc_pkg::*;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic [15:0]        radius_out;
    logic [15:0]        angle_out;
    logic               saturated;
  } conversion_t;

  localparam longint HALF_LSB = longint'(1) << (FRAC_W - 1);

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;  // x_in, y_in, radius_in, angle_in
  logic        s_tuser  = 1'b0; // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // x_out, y_out, radius_out, angle_out
  logic        m_tuser;         // saturated

  conversion_t conversions_due [$];
  conversion_t seen_result;
  conversion_t due_result;
  int          fault_count  = 0;
  int          result_index = 0;
  bit          steady       = 1'b0;

  rect_polar_converter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  function automatic longint unsigned scale_by_gain(longint unsigned v);
    longint unsigned g;
    g = GAIN;
    return (v >> 32) * g + (((v & 64'hFFFF_FFFF) * g) >> 32);
  endfunction

  function automatic longint round_nearest(longint v);
    return (v + HALF_LSB) >>> FRAC_W;
  endfunction

  function automatic logic [15:0] clip_coordinate(longint v, inout bit clip);
    if (v > 32767) begin
      v = 32767;
      clip = 1'b1;
    end
    if (v < -32767) begin
      v = -32767;
      clip = 1'b1;
    end
    return v[15:0];
  endfunction

  function automatic conversion_t predict_conversion(request_t req);
    conversion_t res;
    longint      px, py, nx, ny, zs, mag;
    logic [31:0] zu, zr;
    bit          clip;
    res  = '0;
    clip = 1'b0;
    if (req.opcode == OP_TO_POLAR) begin
      if (req.x_in == 16'sd0 && req.y_in == 16'sd0) return res;
      px = req.x_in;
      py = req.y_in;
      px = px <<< FRAC_W;
      py = py <<< FRAC_W;
      zu = '0;
      // fold the left half plane onto the right one
      if (px < 0) begin
        px = -px;
        py = -py;
        zu = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES; i++) begin
        if (py < 0) begin
          nx = px - (py >>> i);
          ny = py + (px >>> i);
          zu = zu - ATAN_TAB[i];
        end else begin
          nx = px + (py >>> i);
          ny = py - (px >>> i);
          zu = zu + ATAN_TAB[i];
        end
        px = nx;
        py = ny;
      end
      if (px < 0) px = 0;
      mag = round_nearest(longint'(scale_by_gain(px)));
      if (mag > 65535) mag = 65535;
      res.radius_out = mag[15:0];
      zr = zu + 32'h0000_8000;
      res.angle_out = zr[31:16];
    end else begin
      zu = {req.angle_in, 16'h0000};
      px = longint'(scale_by_gain({32'h0, req.radius_in, 16'h0000}));
      py = 0;
      // turn the back half around so the iterations stay within a half turn
      if (zu[31:30] == 2'b01 || zu[31:30] == 2'b10) begin
        px = -px;
        zu = zu - 32'h8000_0000;
      end
      zs = signed'(zu);
      for (int i = 0; i < STAGES; i++) begin
        if (zs < 0) begin
          nx = px + (py >>> i);
          ny = py - (px >>> i);
          zs = zs + longint'(ATAN_TAB[i]);
        end else begin
          nx = px - (py >>> i);
          ny = py + (px >>> i);
          zs = zs - longint'(ATAN_TAB[i]);
        end
        px = nx;
        py = ny;
      end
      res.x_out     = clip_coordinate(round_nearest(px), clip);
      res.y_out     = clip_coordinate(round_nearest(py), clip);
      res.saturated = clip;
    end
    return res;
  endfunction

  function automatic request_t make_request(opcode_t op, int a, int b);
    request_t req;
    req.opcode    = op;
    req.x_in      = 16'($urandom);
    req.y_in      = 16'($urandom);
    req.radius_in = 16'($urandom);
    req.angle_in  = 16'($urandom);
    if (op == OP_TO_POLAR) begin
      req.x_in = 16'(a);
      req.y_in = 16'(b);
    end else begin
      req.radius_in = 16'(a);
      req.angle_in  = 16'(b);
    end
    return req;
  endfunction

  function automatic request_t random_request();
    int       edges [6] = '{-32768, -32767, -1, 0, 1, 32767};
    int       radii [6] = '{0, 1, 32767, 32768, 46341, 65535};
    int       a, b;
    opcode_t  op;
    op = $urandom_range(1) ? OP_TO_RECT : OP_TO_POLAR;
    a  = $urandom_range(65535);
    b  = $urandom_range(65535);
    if (op == OP_TO_POLAR) begin
      case ($urandom_range(9))
        0: begin
          a = int'($urandom_range(32)) - 16;
          b = int'($urandom_range(32)) - 16;
        end
        1: if ($urandom_range(1)) a = 0; else b = 0;
        2: begin
          a = edges[$urandom_range(5)];
          b = edges[$urandom_range(5)];
        end
        default: ;
      endcase
    end else begin
      case ($urandom_range(9))
        0: a = $urandom_range(40);
        1: a = radii[$urandom_range(5)];
        2: a = $urandom_range(65535, 46341);
        3: b = ($urandom_range(7) * 8192 + int'($urandom_range(2)) - 1) & 16'hFFFF;
        default: ;
      endcase
    end
    return make_request(op, a, b);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fault_count++;
  endtask

  task automatic send_request(request_t req);
    while (take_break()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.opcode;
    s_tdata  <= {req.angle_in, req.radius_in, req.y_in, req.x_in};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    conversions_due.push_back(predict_conversion(req));
  endtask

  task automatic test_polar_corners();
    int pts [15][2] = '{
      '{0, 0}, '{32767, 0}, '{-32768, 0}, '{0, 32767}, '{0, -32768},
      '{32767, 32767}, '{-32768, -32768}, '{-32768, 32767}, '{32767, -32768},
      '{-1, 0}, '{-5, 1}, '{-5, -1}, '{32767, -1}, '{1, 0}, '{0, -1}
    };
    foreach (pts[i]) send_request(make_request(OP_TO_POLAR, pts[i][0], pts[i][1]));
  endtask

  task automatic test_rect_corners();
    int pts [11][2] = '{
      '{0, 0}, '{65535, 0}, '{65535, 8192}, '{65535, 16384}, '{32767, 16383},
      '{32767, 32768}, '{46341, 49152}, '{1000, 49151}, '{65535, 65535},
      '{1, 12345}, '{32768, 24576}
    };
    foreach (pts[i]) send_request(make_request(OP_TO_RECT, pts[i][0], pts[i][1]));
  endtask

  task automatic test_random_requests(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_back_to_back(int count);
    steady = 1'b1;
    repeat (count) send_request(random_request());
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    m_tready <= !take_break();
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                     m_tuser};
      if (conversions_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request pending",
                                  result_index));
      end else begin
        due_result = conversions_due.pop_front();
        if (seen_result.x_out !== due_result.x_out)
          report_mismatch($sformatf("result %0d x_out got %0d want %0d", result_index,
                                    seen_result.x_out, due_result.x_out));
        if (seen_result.y_out !== due_result.y_out)
          report_mismatch($sformatf("result %0d y_out got %0d want %0d", result_index,
                                    seen_result.y_out, due_result.y_out));
        if (seen_result.radius_out !== due_result.radius_out)
          report_mismatch($sformatf("result %0d radius_out got %0d want %0d",
                                    result_index, seen_result.radius_out,
                                    due_result.radius_out));
        if (seen_result.angle_out !== due_result.angle_out)
          report_mismatch($sformatf("result %0d angle_out got %0d want %0d",
                                    result_index, seen_result.angle_out,
                                    due_result.angle_out));
        if (seen_result.saturated !== due_result.saturated)
          report_mismatch($sformatf("result %0d saturated got %0b want %0b",
                                    result_index, seen_result.saturated,
                                    due_result.saturated));
      end
      result_index++;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_polar_corners();
    test_rect_corners();
    test_random_requests(1250);
    test_back_to_back(400);
    s_tvalid <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
